/* hw/rtl/x86alu_pkg.sv */
package x86alu_pkg;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_ADC = 3'd2;
	localparam logic [2:0] OP_SBB = 3'd3;
	localparam logic [2:0] OP_AND = 3'd4;
	localparam logic [2:0] OP_OR  = 3'd5;
	localparam logic [2:0] OP_XOR = 3'd6;

	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_WORD = 2'd1;

	localparam logic [31:0] MASK_BYTE  = 32'h0000_00ff;
	localparam logic [31:0] MASK_WORD  = 32'h0000_ffff;
	localparam logic [31:0] MASK_DWORD = 32'hffff_ffff;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [1:0]  op_size;
		logic [31:0] operand_a;
		logic [31:0] operand_b;
		logic        carry_in;
	} req_t;

	typedef struct packed {
		logic [31:0] result;
		logic        of;
		logic        sf;
		logic        zf;
		logic        af;
		logic        pf;
		logic        cf;
	} rsp_t;

	// aux carry write back to the kept flag
	typedef struct packed {
		logic we;
		logic af;
	} af_upd_t;

endpackage

/* hw/rtl/x86_integer_alu_flags_top.sv */
// channel | direction | handshake           | payload
// request | in        | in_valid / in_ready | req_type, op_size, operand_a, operand_b, carry_in
// result  | out       | out_valid/out_ready | result, overflow_flag, sign_flag, zero_flag,
//         |           |                     | aux_carry_flag, parity_flag, carry_flag
//
// two register stages: request register, then add/sub and flag logic into the result register
// one request per clock while out_ready is high; out_valid set as it enters the result register
// kept aux carry updates as an arithmetic item enters the result register, so order is kept
// reset clears both valid bits and the kept aux carry
// a stalled result holds the pipe; in_ready stays high while the request stage can move on
module x86_integer_alu_flags_top import x86alu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [1:0]  op_size,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	input  logic        carry_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result,
	output logic        overflow_flag,
	output logic        sign_flag,
	output logic        zero_flag,
	output logic        aux_carry_flag,
	output logic        parity_flag,
	output logic        carry_flag
);

	req_t    req_s1;
	logic    vld_s1;
	rsp_t    rsp_s2;
	logic    vld_s2;
	logic    af_kept_q;
	rsp_t    rsp_nxt;
	af_upd_t af_upd;
	logic    load_s2;
	logic    load_s1;

	assign load_s2  = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || load_s2;
	assign load_s1  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			af_kept_q <= 1'b0;
		end else begin
			if (in_ready)
				vld_s1 <= in_valid;
			if (load_s2)
				vld_s2 <= 1'b1;
			else if (out_ready)
				vld_s2 <= 1'b0;
			if (load_s2 && af_upd.we)
				af_kept_q <= af_upd.af;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			req_s1.req_type  <= req_type;
			req_s1.op_size   <= op_size;
			req_s1.operand_a <= operand_a;
			req_s1.operand_b <= operand_b;
			req_s1.carry_in  <= carry_in;
		end
		if (load_s2)
			rsp_s2 <= rsp_nxt;
	end

	x86alu_core u_core (
		.req     (req_s1),
		.af_kept (af_kept_q),
		.rsp     (rsp_nxt),
		.af_upd  (af_upd)
	);

	assign out_valid      = vld_s2;
	assign result         = rsp_s2.result;
	assign overflow_flag  = rsp_s2.of;
	assign sign_flag      = rsp_s2.sf;
	assign zero_flag      = rsp_s2.zf;
	assign aux_carry_flag = rsp_s2.af;
	assign parity_flag    = rsp_s2.pf;
	assign carry_flag     = rsp_s2.cf;

	// logic ops never report overflow or carry
	a_logic_clears: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 && !af_upd.we |=> !overflow_flag && !carry_flag)
		else $error("logic op left OF or CF set");

	// kept aux carry moves only with an arithmetic op entering the result register
	a_af_kept_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(load_s2 && af_upd.we) |=> $stable(af_kept_q))
		else $error("kept aux carry changed without arithmetic op");

	// logic op returns the kept aux carry
	a_logic_af: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 && !af_upd.we |=> aux_carry_flag == $past(af_kept_q))
		else $error("logic op did not return kept aux carry");

	a_zero_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> zero_flag == (result == 32'd0))
		else $error("zero flag disagrees with result");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> in_ready)
		else $error("empty request stage not ready");

endmodule

/* hw/rtl/x86alu_core.sv */
module x86alu_core import x86alu_pkg::*; (
	input  req_t    req,
	input  logic    af_kept,
	output rsp_t    rsp,
	output af_upd_t af_upd
);

	logic [31:0] mask;
	logic [31:0] a;
	logic [31:0] b;
	logic        c;
	logic [32:0] sum;
	logic [32:0] diff;
	logic [31:0] res;
	logic [31:0] ovf_vec;
	logic [32:0] wide;
	logic        is_add;
	logic        is_sub;
	logic        top_bit;
	logic        top_ovf;
	logic        carry_out;
	logic        af_arith;

	always_comb begin
		case (req.op_size)
			SZ_BYTE: mask = MASK_BYTE;
			SZ_WORD: mask = MASK_WORD;
			default: mask = MASK_DWORD;
		endcase
	end

	assign a      = req.operand_a & mask;
	assign b      = req.operand_b & mask;
	assign is_add = (req.req_type == OP_ADD) || (req.req_type == OP_ADC);
	assign is_sub = (req.req_type == OP_SUB) || (req.req_type == OP_SBB);
	assign c      = ((req.req_type == OP_ADC) || (req.req_type == OP_SBB)) ? req.carry_in : 1'b0;

	// operands are masked, so bit at the size position is the carry or borrow
	assign sum  = {1'b0, a} + {1'b0, b} + {32'd0, c};
	assign diff = {1'b0, a} - {1'b0, b} - {32'd0, c};

	always_comb begin
		wide    = 33'd0;
		ovf_vec = 32'd0;
		case (req.req_type)
			OP_ADD, OP_ADC: begin
				wide    = sum;
				ovf_vec = (a ^ sum[31:0]) & (b ^ sum[31:0]);
			end
			OP_SUB, OP_SBB: begin
				wide    = diff;
				ovf_vec = (a ^ b) & (a ^ diff[31:0]);
			end
			OP_AND:  wide = {1'b0, a & b};
			OP_OR:   wide = {1'b0, a | b};
			OP_XOR:  wide = {1'b0, a ^ b};
			default: wide = 33'd0;
		endcase
	end

	assign res = wide[31:0] & mask;

	always_comb begin
		case (req.op_size)
			SZ_BYTE: begin
				top_bit   = res[7];
				top_ovf   = ovf_vec[7];
				carry_out = wide[8];
			end
			SZ_WORD: begin
				top_bit   = res[15];
				top_ovf   = ovf_vec[15];
				carry_out = wide[16];
			end
			default: begin
				top_bit   = res[31];
				top_ovf   = ovf_vec[31];
				carry_out = wide[32];
			end
		endcase
	end

	assign af_arith = a[4] ^ b[4] ^ res[4];

	assign rsp.result = res;
	assign rsp.of     = (is_add || is_sub) ? top_ovf : 1'b0;
	assign rsp.cf     = (is_add || is_sub) ? carry_out : 1'b0;
	assign rsp.sf     = top_bit;
	assign rsp.zf     = (res == 32'd0);
	assign rsp.af     = (is_add || is_sub) ? af_arith : af_kept;
	assign rsp.pf     = ~^res[7:0];

	assign af_upd.we = is_add || is_sub;
	assign af_upd.af = af_arith;

endmodule
